// ----- src/hwcu_pkg.sv -----
// ----------------------------------------------------------------------------
// hwcu_pkg
// shared constants for the histogram window centroid unit: register map,
// command codes, reset values, default grid size and count limit
// ----------------------------------------------------------------------------
package hwcu_pkg;

    localparam int BINS_X_DEF = 128;
    localparam int BINS_Y_DEF = 128;

    localparam int COUNT_W = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BW_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BW_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd6;

    localparam logic [31:0] X_LOW_RST   = 32'd0;
    localparam logic [31:0] Y_LOW_RST   = 32'd0;
    localparam logic [30:0] BW_RST      = 31'd655;
    localparam logic [30:0] PITCH_RST   = 31'd65536;
    localparam logic [31:0] FLOOR_RST   = 32'd50;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

endpackage

// ----- src/histogram_window_centroid_unit.sv -----
// ----------------------------------------------------------------------------
// histogram_window_centroid_unit
// 2d hit-count histogram with a pixel-window weighted centroid
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken when start is high and busy is low. func selects
//   clear, add point or query centroid; pos_x / pos_y are q16.16 positions.
//   each command gives one result beat, shown for one cycle with done high;
//   the receiver cannot stall it. registers are to be written over the apb port
//   only while the block is idle; the block itself does not enforce this.
// commands (one shared restoring divider serves every division):
//   clear: one store entry per cycle over the whole store
//   add:   2 divisions, then a read and a write of the bin, or
//          only the 2 divisions when the point is rejected
//   query: 4 divisions and a walk over the window bins, and when trusted
//          two more shift-add multiplies and 2 divisions
//   unknown func: a result beat with ok low
// reset: the block runs a clearing pass over all BINS_X*BINS_Y store entries
// (16384 at the default grid) with busy high; config writes are taken
// meanwhile.
// ----------------------------------------------------------------------------
module histogram_window_centroid_unit
    import hwcu_pkg::*;
#(
    parameter int BINS_X = BINS_X_DEF,
    parameter int BINS_Y = BINS_Y_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            func,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    output logic                  done,
    output logic                  ok,
    output logic signed [31:0]    centroid_x,
    output logic signed [31:0]    centroid_y,
    output logic [31:0]           window_weight,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int DEPTH  = BINS_X * BINS_Y;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IX_W   = $clog2((BINS_X > 1) ? BINS_X : 2);
    localparam int IY_W   = $clog2((BINS_Y > 1) ? BINS_Y : 2);
    localparam int KX_W   = IX_W + 1;
    localparam int KY_W   = IY_W + 1;
    localparam int SW_A   = $clog2(DEPTH + 1) + COUNT_W + 1;
    localparam int SW_W   = (SW_A > 33) ? SW_A : 33;
    localparam int SX_W   = SW_W + KX_W;
    localparam int SY_W   = SW_W + KY_W;
    localparam int S_W    = (SX_W > SY_W) ? SX_W : SY_W;
    localparam int PW     = S_W + 31;
    localparam int DVD_W  = PW;
    localparam int DVS_W  = SW_W + 1;
    localparam int CW     = DVD_W + 2;

    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b0000000001,
        ST_IDLE    = 10'b0000000010,
        ST_DIVLOAD = 10'b0000000100,
        ST_DIVWAIT = 10'b0000001000,
        ST_READ    = 10'b0000010000,
        ST_WRITE   = 10'b0000100000,
        ST_WALK    = 10'b0001000000,
        ST_DRAIN   = 10'b0010000000,
        ST_CHECK   = 10'b0100000000,
        ST_MUL     = 10'b1000000000
    } state_t;

    typedef enum logic [2:0] {
        J_AX, J_AY, J_QX0, J_QX1, J_QY0, J_QY1, J_CX, J_CY
    } job_t;

    // config registers
    logic [31:0] x_low_reg, y_low_reg, floor_reg;
    logic [30:0] bwx_reg, bwy_reg, ppx_reg, ppy_reg;
    logic        cfg_we;

    state_t               state_reg, state_next;
    job_t                 job_reg, job_next;
    logic signed [31:0]   px_reg, px_next, py_reg, py_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next, base_reg, base_next;
    logic                 clr_item_reg, clr_item_next;
    logic [DVD_W-1:0]     qx_reg, qx_next;
    logic [IX_W-1:0]      ix0_reg, ix0_next, ix1_reg, ix1_next, ix_reg, ix_next;
    logic [IY_W-1:0]      iy0_reg, iy0_next, iy1_reg, iy1_next, iy_reg, iy_next;
    logic                 pv_reg, pv_next;
    logic [KX_W-1:0]      kx_reg, kx_next;
    logic [KY_W-1:0]      ky_reg, ky_next;
    logic [SW_W-1:0]      sw_reg, sw_next;
    logic [SX_W-1:0]      sx_reg, sx_next;
    logic [SY_W-1:0]      sy_reg, sy_next;
    logic [PW-1:0]        mcand_reg, mcand_next, prod_reg, prod_next;
    logic [30:0]          mplier_reg, mplier_next;
    logic [4:0]           mcnt_reg, mcnt_next;
    logic                 ok_reg, ok_next, done_reg, done_next;
    logic [31:0]          cx_reg, cx_next, cy_reg, cy_next, ww_reg, ww_next;

    // store
    logic [COUNT_W-1:0]   mem [DEPTH];
    logic [COUNT_W-1:0]   rd_q;
    logic                 mem_we;
    logic [COUNT_W-1:0]   mem_wd;

    // divider
    logic                 div_start, div_done;
    logic [DVD_W-1:0]     div_dvd, quot;
    logic [DVS_W-1:0]     div_dvs;

    logic [30:0]          bwx_eff, bwy_eff;
    logic signed [34:0]   dx, dy, nx0, nx1, ny0, ny1;
    logic                 num_neg;
    logic [IX_W-1:0]      edge_x;
    logic [IY_W-1:0]      edge_y;
    logic [20+KX_W-1:0]   wkx;
    logic [20+KY_W-1:0]   wky;
    logic signed [CW-1:0] c_sum, low_ext;
    logic [31:0]          c_sat, low_sel;
    logic [31:0]          ww_sat;
    logic                 add_ok;

    localparam logic signed [CW-1:0] C_MAX = {{(CW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {{(CW-31){1'b1}}, {31{1'b0}}};

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg <= X_LOW_RST;
            y_low_reg <= Y_LOW_RST;
            bwx_reg   <= BW_RST;
            bwy_reg   <= BW_RST;
            ppx_reg   <= PITCH_RST;
            ppy_reg   <= PITCH_RST;
            floor_reg <= FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[CFG_ADDR_W-1:2])
                REG_X_LOW:   x_low_reg <= pwdata;
                REG_Y_LOW:   y_low_reg <= pwdata;
                REG_BW_X:    bwx_reg   <= pwdata[30:0];
                REG_BW_Y:    bwy_reg   <= pwdata[30:0];
                REG_PITCH_X: ppx_reg   <= pwdata[30:0];
                REG_PITCH_Y: ppy_reg   <= pwdata[30:0];
                REG_FLOOR:   floor_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[CFG_ADDR_W-1:2])
            REG_X_LOW:   prdata = x_low_reg;
            REG_Y_LOW:   prdata = y_low_reg;
            REG_BW_X:    prdata = {1'b0, bwx_reg};
            REG_BW_Y:    prdata = {1'b0, bwy_reg};
            REG_PITCH_X: prdata = {1'b0, ppx_reg};
            REG_PITCH_Y: prdata = {1'b0, ppy_reg};
            REG_FLOOR:   prdata = floor_reg;
            default:     prdata = '0;
        endcase
    end

    // operand preparation
    assign bwx_eff = (bwx_reg == '0) ? 31'd1 : bwx_reg;
    assign bwy_eff = (bwy_reg == '0) ? 31'd1 : bwy_reg;
    assign dx  = {{3{px_reg[31]}}, px_reg} - {{3{x_low_reg[31]}}, x_low_reg};
    assign dy  = {{3{py_reg[31]}}, py_reg} - {{3{y_low_reg[31]}}, y_low_reg};
    assign nx0 = (dx <<< 1) - $signed({4'b0, ppx_reg});
    assign nx1 = (dx <<< 1) + $signed({4'b0, ppx_reg});
    assign ny0 = (dy <<< 1) - $signed({4'b0, ppy_reg});
    assign ny1 = (dy <<< 1) + $signed({4'b0, ppy_reg});

    always_comb
    begin
        div_dvd = '0;
        div_dvs = '0;
        num_neg = 1'b0;
        case (job_reg)
            J_AX:
            begin
                div_dvd = DVD_W'(dx[31:0]);
                div_dvs = DVS_W'(bwx_eff);
            end
            J_AY:
            begin
                div_dvd = DVD_W'(dy[31:0]);
                div_dvs = DVS_W'(bwy_eff);
            end
            J_QX0:
            begin
                div_dvd = DVD_W'(nx0[33:0]);
                div_dvs = DVS_W'({bwx_eff, 1'b0});
                num_neg = nx0[34];
            end
            J_QX1:
            begin
                div_dvd = DVD_W'(nx1[33:0]);
                div_dvs = DVS_W'({bwx_eff, 1'b0});
                num_neg = nx1[34];
            end
            J_QY0:
            begin
                div_dvd = DVD_W'(ny0[33:0]);
                div_dvs = DVS_W'({bwy_eff, 1'b0});
                num_neg = ny0[34];
            end
            J_QY1:
            begin
                div_dvd = DVD_W'(ny1[33:0]);
                div_dvs = DVS_W'({bwy_eff, 1'b0});
                num_neg = ny1[34];
            end
            J_CX, J_CY:
            begin
                div_dvd = prod_reg;
                div_dvs = {sw_reg, 1'b0};
            end
            default: ;
        endcase
    end

    hwcu_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quot)
    );

    // clamped window edges
    always_comb
    begin
        if (num_neg)
            edge_x = '0;
        else if (quot > DVD_W'(BINS_X - 1))
            edge_x = IX_W'(BINS_X - 1);
        else
            edge_x = quot[IX_W-1:0];
        if (num_neg)
            edge_y = '0;
        else if (quot > DVD_W'(BINS_Y - 1))
            edge_y = IY_W'(BINS_Y - 1);
        else
            edge_y = quot[IY_W-1:0];
    end

    // centroid offset and saturation
    assign low_sel = (job_reg == J_CX) ? x_low_reg : y_low_reg;
    assign low_ext = {{(CW-32){low_sel[31]}}, low_sel};
    assign c_sum   = low_ext + $signed({2'b00, quot});

    always_comb
    begin
        if (c_sum > C_MAX)
            c_sat = 32'h7fff_ffff;
        else if (c_sum < C_MIN)
            c_sat = 32'h8000_0000;
        else
            c_sat = c_sum[31:0];
    end

    assign ww_sat = (|sw_reg[SW_W-1:32]) ? 32'hffff_ffff : sw_reg[31:0];
    assign add_ok = !dx[34] && !dy[34] && (qx_reg < DVD_W'(BINS_X))
                    && (quot < DVD_W'(BINS_Y));
    assign wkx = (20+KX_W)'(rd_q) * (20+KX_W)'(kx_reg);
    assign wky = (20+KY_W)'(rd_q) * (20+KY_W)'(ky_reg);

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        addr_next     = addr_reg;
        base_next     = base_reg;
        clr_item_next = clr_item_reg;
        qx_next       = qx_reg;
        ix0_next      = ix0_reg;
        ix1_next      = ix1_reg;
        iy0_next      = iy0_reg;
        iy1_next      = iy1_reg;
        ix_next       = ix_reg;
        iy_next       = iy_reg;
        pv_next       = 1'b0;
        kx_next       = kx_reg;
        ky_next       = ky_reg;
        sw_next       = sw_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        mcnt_next     = mcnt_reg;
        ok_next       = ok_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        ww_next       = ww_reg;
        done_next     = 1'b0;
        div_start     = 1'b0;
        mem_we        = 1'b0;
        mem_wd        = '0;

        // window accumulation, in the cycle after the read
        if (pv_reg)
        begin
            sw_next = sw_reg + SW_W'(rd_q);
            sx_next = sx_reg + SX_W'(wkx);
            sy_next = sy_reg + SY_W'(wky);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                    if (clr_item_reg)
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b1;
                        cx_next   = '0;
                        cy_next   = '0;
                        ww_next   = '0;
                    end
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    px_next = pos_x;
                    py_next = pos_y;
                    ok_next = 1'b0;
                    cx_next = '0;
                    cy_next = '0;
                    ww_next = '0;
                    case (func)
                        FUNC_CLEAR:
                        begin
                            addr_next     = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        FUNC_ADD:
                        begin
                            job_next   = J_AX;
                            state_next = ST_DIVLOAD;
                        end
                        FUNC_QUERY:
                        begin
                            job_next   = J_QX0;
                            state_next = ST_DIVLOAD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIVLOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DIVLOAD;
                    case (job_reg)
                        J_AX:
                        begin
                            qx_next  = quot;
                            job_next = J_AY;
                        end
                        J_AY:
                        begin
                            addr_next = ADDR_W'(qx_reg[IX_W-1:0]) * ADDR_W'(BINS_Y)
                                        + ADDR_W'(quot[IY_W-1:0]);
                            if (add_ok)
                                state_next = ST_READ;
                            else
                            begin
                                state_next = ST_IDLE;
                                done_next  = 1'b1;
                            end
                        end
                        J_QX0:
                        begin
                            ix0_next = edge_x;
                            job_next = J_QX1;
                        end
                        J_QX1:
                        begin
                            ix1_next = edge_x;
                            job_next = J_QY0;
                        end
                        J_QY0:
                        begin
                            iy0_next = edge_y;
                            job_next = J_QY1;
                        end
                        J_QY1:
                        begin
                            iy1_next   = edge_y;
                            ix_next    = ix0_reg;
                            iy_next    = iy0_reg;
                            base_next  = ADDR_W'(ix0_reg) * ADDR_W'(BINS_Y);
                            addr_next  = ADDR_W'(ix0_reg) * ADDR_W'(BINS_Y)
                                         + ADDR_W'(iy0_reg);
                            sw_next    = '0;
                            sx_next    = '0;
                            sy_next    = '0;
                            state_next = ST_WALK;
                        end
                        J_CX:
                        begin
                            cx_next     = c_sat;
                            job_next    = J_CY;
                            mcand_next  = PW'(sy_reg);
                            mplier_next = bwy_eff;
                            prod_next   = '0;
                            mcnt_next   = '0;
                            state_next  = ST_MUL;
                        end
                        default:
                        begin
                            cy_next    = c_sat;
                            ok_next    = 1'b1;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                mem_wd     = (rd_q == COUNT_MAX) ? rd_q : rd_q + 1'b1;
                ok_next    = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                pv_next = 1'b1;
                kx_next = {ix_reg, 1'b1};
                ky_next = {iy_reg, 1'b1};
                if (iy_reg == iy1_reg)
                begin
                    if (ix_reg == ix1_reg)
                        state_next = ST_DRAIN;
                    else
                    begin
                        ix_next   = ix_reg + 1'b1;
                        iy_next   = iy0_reg;
                        base_next = base_reg + ADDR_W'(BINS_Y);
                        addr_next = base_reg + ADDR_W'(BINS_Y) + ADDR_W'(iy0_reg);
                    end
                end
                else
                begin
                    iy_next   = iy_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ww_next = ww_sat;
                if ((sw_reg != '0) && (sw_reg >= SW_W'(floor_reg)))
                begin
                    job_next    = J_CX;
                    mcand_next  = PW'(sx_reg);
                    mplier_next = bwx_eff;
                    prod_next   = '0;
                    mcnt_next   = '0;
                    state_next  = ST_MUL;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                    prod_next = prod_reg + mcand_reg;
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[30:1]};
                mcnt_next   = mcnt_reg + 1'b1;
                if (mcnt_reg == 5'd30)
                    state_next = ST_DIVLOAD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            job_reg      <= J_AX;
            addr_reg     <= '0;
            clr_item_reg <= 1'b0;
            pv_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            addr_reg     <= addr_next;
            clr_item_reg <= clr_item_next;
            pv_reg       <= pv_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        base_reg   <= base_next;
        qx_reg     <= qx_next;
        ix0_reg    <= ix0_next;
        ix1_reg    <= ix1_next;
        iy0_reg    <= iy0_next;
        iy1_reg    <= iy1_next;
        ix_reg     <= ix_next;
        iy_reg     <= iy_next;
        kx_reg     <= kx_next;
        ky_reg     <= ky_next;
        sw_reg     <= sw_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        mcnt_reg   <= mcnt_next;
        ok_reg     <= ok_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        ww_reg     <= ww_next;
    end

    // hit count store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wd;
        rd_q <= mem[addr_reg];
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign ok            = ok_reg;
    assign centroid_x    = cx_reg;
    assign centroid_y    = cy_reg;
    assign window_weight = ww_reg;

endmodule

// ----- src/hwcu_div.sv -----
// ----------------------------------------------------------------------------
// hwcu_div
// restoring divider, one quotient bit per cycle, shared by all divisions
// ----------------------------------------------------------------------------
module hwcu_div #(
    parameter int DVD_W = 66,
    parameter int DVS_W = 35
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;

    assign rem_sh = {rem_reg, q_reg[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for histogram_window_centroid_unit
// drives clear, add, query and unknown commands with a mix of directed and random
// positions around a hot spot of the grid, over several register settings
// and idle patterns; a scoreboard keeps its own copy of the hit counts and
// checks every result beat field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import hwcu_pkg::*;

    localparam int NX = BINS_X_DEF;
    localparam int NY = BINS_Y_DEF;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic        ok;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] wt;
    } centroid_beat_t;

    class centroid_board;
        int unsigned counts[NX*NY];
        logic [31:0] regs[7];
        centroid_beat_t awaited[$];
        int errors;
        int n_add_ok;
        int n_trusted;

        function new();
            regs[REG_X_LOW]   = X_LOW_RST;
            regs[REG_Y_LOW]   = Y_LOW_RST;
            regs[REG_BW_X]    = {1'b0, BW_RST};
            regs[REG_BW_Y]    = {1'b0, BW_RST};
            regs[REG_PITCH_X] = {1'b0, PITCH_RST};
            regs[REG_PITCH_Y] = {1'b0, PITCH_RST};
            regs[REG_FLOOR]   = FLOOR_RST;
            foreach (counts[i]) counts[i] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            if (idx == REG_BW_X || idx == REG_BW_Y || idx == REG_PITCH_X ||
                idx == REG_PITCH_Y)
                v[31] = 1'b0;
            regs[idx] = v;
        endfunction

        function longint width_of(logic [2:0] idx);
            return (regs[idx] == 0) ? 64'sd1 : longint'(regs[idx]);
        endfunction

        function longint bin_index(longint p, longint lo, longint bw, longint n);
            longint d;
            d = p - lo;
            if (d < 0) return -1;
            return (d / bw < n) ? d / bw : -1;
        endfunction

        function longint edge_index(longint num, longint bw, longint n);
            if (num < 0) return 0;
            return (num / (2 * bw) > n - 1) ? n - 1 : num / (2 * bw);
        endfunction

        function logic [31:0] mean_pos(longint lo, longint bw,
                                       longint unsigned s, longint unsigned sw);
            longint unsigned d, a, r;
            logic [127:0] prod;
            longint c;
            d = 2 * sw;
            a = s / d;
            r = s % d;
            prod = 128'(bw) * 128'(r);
            c = lo + bw * longint'(a) + longint'(prod / 128'(d));
            if (c > 64'sd2147483647) c = 64'sd2147483647;
            if (c < -64'sd2147483648) c = -64'sd2147483648;
            return c[31:0];
        endfunction

        function void note_command(logic [1:0] f, logic signed [31:0] x,
                                   logic signed [31:0] y);
            centroid_beat_t e;
            longint px, py, xl, yl, bwx, bwy, ix, iy, ix0, ix1, iy0, iy1;
            longint unsigned sw, sx, sy, w;
            px = x;
            py = y;
            xl = signed'(regs[REG_X_LOW]);
            yl = signed'(regs[REG_Y_LOW]);
            bwx = width_of(REG_BW_X);
            bwy = width_of(REG_BW_Y);
            e = '0;
            case (f)
                FUNC_CLEAR:
                begin
                    foreach (counts[i]) counts[i] = 0;
                    e.ok = 1'b1;
                end
                FUNC_ADD:
                begin
                    ix = bin_index(px, xl, bwx, NX);
                    iy = bin_index(py, yl, bwy, NY);
                    if (ix >= 0 && iy >= 0)
                    begin
                        if (counts[ix*NY+iy] < COUNT_MAX) counts[ix*NY+iy]++;
                        e.ok = 1'b1;
                        n_add_ok++;
                    end
                end
                FUNC_QUERY:
                begin
                    ix0 = edge_index(2*(px-xl) - longint'(regs[REG_PITCH_X]), bwx, NX);
                    ix1 = edge_index(2*(px-xl) + longint'(regs[REG_PITCH_X]), bwx, NX);
                    iy0 = edge_index(2*(py-yl) - longint'(regs[REG_PITCH_Y]), bwy, NY);
                    iy1 = edge_index(2*(py-yl) + longint'(regs[REG_PITCH_Y]), bwy, NY);
                    sw = 0;
                    sx = 0;
                    sy = 0;
                    for (ix = ix0; ix <= ix1; ix++)
                        for (iy = iy0; iy <= iy1; iy++)
                        begin
                            w = counts[ix*NY+iy];
                            sw += w;
                            sx += w * longint'(2*ix + 1);
                            sy += w * longint'(2*iy + 1);
                        end
                    e.wt = (sw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sw[31:0];
                    if (sw != 0 && sw >= longint'(regs[REG_FLOOR]))
                    begin
                        e.ok = 1'b1;
                        e.cx = mean_pos(xl, bwx, sx, sw);
                        e.cy = mean_pos(yl, bwy, sy, sw);
                        n_trusted++;
                    end
                end
                default: ;
            endcase
            awaited.insert(awaited.size(), e);
        endfunction

        function void check_result(centroid_beat_t got);
            centroid_beat_t e;
            if (awaited.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (got.ok !== e.ok)
            begin
                $error("ok: expected %0d, got %0d", e.ok, got.ok);
                errors++;
            end
            if (got.cx !== e.cx)
            begin
                $error("centroid_x: expected %0d, got %0d", $signed(e.cx), $signed(got.cx));
                errors++;
            end
            if (got.cy !== e.cy)
            begin
                $error("centroid_y: expected %0d, got %0d", $signed(e.cy), $signed(got.cy));
                errors++;
            end
            if (got.wt !== e.wt)
            begin
                $error("window_weight: expected %0d, got %0d", e.wt, got.wt);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            func = FUNC_CLEAR;
    logic signed [31:0]    pos_x = '0;
    logic signed [31:0]    pos_y = '0;
    logic                  done;
    logic                  ok;
    logic signed [31:0]    centroid_x;
    logic signed [31:0]    centroid_y;
    logic [31:0]           window_weight;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    centroid_board board = new();
    int n_cmds;
    int hot_x, hot_y;

    always #2 clk = ~clk;

    histogram_window_centroid_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .pos_x(pos_x), .pos_y(pos_y), .done(done), .ok(ok),
        .centroid_x(centroid_x), .centroid_y(centroid_y),
        .window_weight(window_weight), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // beat monitor
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            board.note_command(func, pos_x, pos_y);
            n_cmds++;
        end
        if (rst_n && done)
            board.check_result({ok, centroid_x, centroid_y, window_weight});
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.write_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic issue(logic [1:0] f, logic [31:0] x, logic [31:0] y, int idle_pct);
        func <= f;
        pos_x <= x;
        pos_y <= y;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_pos(logic [2:0] lo_idx, logic [2:0] bw_idx,
                                             int hot);
        longint lo, bw, off, span;
        int r;
        lo = signed'(board.regs[lo_idx]);
        bw = board.width_of(bw_idx);
        span = bw * NX;
        r = $urandom_range(99);
        if (r < 70)
            off = (hot + $urandom_range(7)) * bw + $urandom_range(32'(bw - 1));
        else if (r < 90)
            off = longint'({$urandom, $urandom} % (span + span / 4)) - span / 8;
        else
            return $urandom;
        off = lo + off;
        if (off > 64'sd2147483647) off = 64'sd2147483647;
        if (off < -64'sd2147483648) off = -64'sd2147483648;
        return off[31:0];
    endfunction

    task automatic random_run(int count, int idle_pct);
        int r;
        logic [1:0] f;
        repeat (count)
        begin
            r = $urandom_range(999);
            if (r < 5) f = FUNC_CLEAR;
            else if (r < 55) f = FUNC_NONE;
            else if (r < 530) f = FUNC_ADD;
            else f = FUNC_QUERY;
            if (f == FUNC_NONE && $urandom_range(1))
                issue(f, $urandom, $urandom, idle_pct);
            else
                issue(f, pick_pos(REG_X_LOW, REG_BW_X, hot_x),
                      pick_pos(REG_Y_LOW, REG_BW_Y, hot_y), idle_pct);
        end
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, written back explicitly
        reg_write(REG_X_LOW, 32'd0);
        reg_write(REG_Y_LOW, 32'd0);
        reg_write(REG_BW_X, 32'd655);
        reg_write(REG_BW_Y, 32'd655);
        reg_write(REG_PITCH_X, 32'd65536);
        reg_write(REG_PITCH_Y, 32'd65536);
        reg_write(REG_FLOOR, 32'd50);

        issue(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(FUNC_ADD, 32'd0, 32'd0, 0);
        issue(FUNC_ADD, 32'hFFFF_FFFF, 32'd10, 0);
        issue(FUNC_ADD, 32'd10, 32'h8000_0000, 0);
        issue(FUNC_ADD, 32'h7FFF_FFFF, 32'd10, 0);
        issue(FUNC_ADD, 32'd83839, 32'd83839, 0);
        issue(FUNC_ADD, 32'd83840, 32'd5, 0);
        issue(FUNC_ADD, 32'd1000, 32'd83840, 0);
        repeat (60) issue(FUNC_ADD, $urandom_range(3000), $urandom_range(3000), 0);
        issue(FUNC_QUERY, 32'd1000, 32'd1000, 0);
        issue(FUNC_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        issue(FUNC_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        issue(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(FUNC_NONE, 32'd0, 32'd0, 0);
        drain();
        reg_write(REG_PITCH_X, 32'h7FFF_FFFF);
        reg_write(REG_PITCH_Y, 32'hFFFF_FFFF);
        reg_write(REG_FLOOR, 32'd0);
        issue(FUNC_QUERY, 32'd500, 32'd500, 0);
        issue(FUNC_CLEAR, 32'd0, 32'd0, 0);
        issue(FUNC_QUERY, 32'd500, 32'd500, 0);
        drain();

        // phase: no idling, plain grid
        reg_write(REG_X_LOW, $urandom_range(200000) - 100000);
        reg_write(REG_Y_LOW, $urandom_range(200000) - 100000);
        reg_write(REG_PITCH_X, 32'd1310);
        reg_write(REG_PITCH_Y, 32'd2000);
        reg_write(REG_FLOOR, 32'd3);
        hot_x = $urandom_range(120);
        hot_y = 0;
        random_run(350, 0);

        // phase: sender mostly idle, unit and zero bin widths near the ends of the position range
        reg_write(REG_X_LOW, 32'h8000_0000);
        reg_write(REG_Y_LOW, 32'h7FFF_FF00);
        reg_write(REG_BW_X, 32'd1);
        reg_write(REG_BW_Y, 32'd0);
        reg_write(REG_PITCH_X, 32'd1);
        reg_write(REG_PITCH_Y, 32'd3);
        reg_write(REG_FLOOR, 32'd0);
        hot_x = 0;
        hot_y = 120;
        random_run(350, 79);

        // phase: widest x bins and x pitch, centroid saturation, floor first never met, then 1
        reg_write(REG_X_LOW, 32'h7FFF_FFFF);
        reg_write(REG_Y_LOW, 32'h8000_0000);
        reg_write(REG_BW_X, 32'h7FFF_FFFF);
        reg_write(REG_BW_Y, 32'd100);
        reg_write(REG_PITCH_X, 32'h7FFF_FFFF);
        reg_write(REG_PITCH_Y, 32'd250);
        reg_write(REG_FLOOR, 32'hFFFF_FFFF);
        hot_x = 0;
        hot_y = $urandom_range(120);
        random_run(150, 0);
        reg_write(REG_FLOOR, 32'd1);
        random_run(150, 23);

        // phase: random geometry
        reg_write(REG_X_LOW, $urandom);
        reg_write(REG_Y_LOW, $urandom);
        reg_write(REG_BW_X, $urandom_range(5000, 1));
        reg_write(REG_BW_Y, $urandom_range(5000, 1));
        reg_write(REG_PITCH_X, $urandom_range(20000, 1));
        reg_write(REG_PITCH_Y, $urandom_range(20000, 1));
        reg_write(REG_FLOOR, 32'd2);
        hot_x = 120;
        hot_y = $urandom_range(120);
        random_run(380, 23);

        $display("covered %0d commands, %0d points binned, %0d trusted centroids",
                 n_cmds, board.n_add_ok, board.n_trusted);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("timeout waiting for the block");
        $display("testbench: errors");
        $finish;
    end

endmodule
